// ===== hdl/sphere_direction_to_pixel_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the direction to panorama pixel block.
// Each macro checks a property on the rising clock edge, outside of reset.
// ----------------------------------------------------------------------------
`ifndef SPHERE_DIRECTION_TO_PIXEL_DEFINES_SVH
`define SPHERE_DIRECTION_TO_PIXEL_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SDP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdp_pkg;

    localparam int COORD_FRAC_BITS = 14;
    localparam int PIXEL_FRAC_BITS = 4;
    localparam int CORDIC_STAGES   = 16;

    localparam int IN_W    = 16;
    localparam int ROOT_W  = COORD_FRAC_BITS + 1;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int GUARD_W = 16;
    localparam int DATA_W  = IN_W + GUARD_W + 2;
    localparam int ACC_W   = 35;
    localparam int ANG_W   = 33;
    localparam int U_W     = 18;
    localparam int V_W     = 17;
    localparam int WIDTH_W = 14;
    localparam int HEIGHT_W = 13;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 14'd1920;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd960;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    function automatic logic [31:0] atan_at(input int k);
        logic [31:0] r;
        unique case (k)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sphere_direction_to_pixel.sv =====
// ----------------------------------------------------------------------------
// sphere_direction_to_pixel
// Maps a Q1.14 direction to sub-pixel coordinates in an equirectangular
// panorama through a square-root pipeline and two CORDIC angle pipelines.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the output is not held,
// and each item passes through one input stage, fifteen square-root stages,
// CORDIC_STAGES + 2 angle stages and one output multiply stage. When the
// output is held, the whole pipeline stalls.
`timescale 1ns / 1ps
`default_nettype none

module sphere_direction_to_pixel #(
    parameter int CORDIC_STAGES = sdp_pkg::CORDIC_STAGES
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [sdp_pkg::IN_W-1:0]      dir_x,
    input  wire logic signed [sdp_pkg::IN_W-1:0]      dir_y,
    input  wire logic signed [sdp_pkg::IN_W-1:0]      dir_z,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [sdp_pkg::U_W-1:0]                   pixel_u,
    output logic [sdp_pkg::V_W-1:0]                   pixel_v,
    input  wire logic                                 cfg_we,
    input  wire logic [0:0]                           cfg_addr,
    input  wire logic [sdp_pkg::WIDTH_W-1:0]          cfg_wdata
);

    localparam int IW     = sdp_pkg::IN_W;
    localparam int ROOT_W = sdp_pkg::ROOT_W;
    localparam int SQ_W   = sdp_pkg::SQ_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int GW     = sdp_pkg::ANG_W;
    localparam int DEPTH  = ROOT_W + CORDIC_STAGES + 4;
    localparam int PFB    = sdp_pkg::PIXEL_FRAC_BITS;
    localparam logic signed [IW-1:0] ONE = IW'(1 << sdp_pkg::COORD_FRAC_BITS);
    localparam logic signed [2*IW-1:0] ONE_SQ = (2*IW)'(64'sd1 << (2*sdp_pkg::COORD_FRAC_BITS));

    logic [DEPTH-1:0]                   vld_reg;
    logic                               adv;
    logic [sdp_pkg::WIDTH_W-1:0]        width_reg;
    logic [sdp_pkg::HEIGHT_W-1:0]       height_reg;

    logic signed [IW-1:0]   x_reg  [0:ROOT_W];
    logic signed [IW-1:0]   z_reg  [0:ROOT_W];
    logic signed [IW-1:0]   yc_reg [0:ROOT_W];
    logic [SQ_W-1:0]        n_reg  [0:ROOT_W];
    logic [REM_W-1:0]       rem_reg [0:ROOT_W];
    logic [ROOT_W-1:0]      root_reg [0:ROOT_W];

    logic signed [IW-1:0]   y_clamp;
    logic signed [2*IW-1:0] y_sq;
    logic [SQ_W-1:0]        n_next;

    logic signed [GW-1:0]   az_ang;
    logic signed [GW-1:0]   pol_ang;
    logic [32:0]            a_val;
    logic [31:0]            b_val;
    logic [46:0]            prod_u;
    logic [44:0]            prod_v;
    logic [sdp_pkg::U_W-1:0] u_reg;
    logic [sdp_pkg::V_W-1:0] v_reg;

    assign adv       = !(vld_reg[DEPTH-1] && !out_ready);
    assign in_ready  = adv;
    assign out_valid = vld_reg[DEPTH-1];
    assign pixel_u   = u_reg;
    assign pixel_v   = v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sdp_pkg::WIDTH_RESET;
            height_reg <= sdp_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sdp_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                sdp_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[sdp_pkg::HEIGHT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (dir_y > ONE)
            y_clamp = ONE;
        else if (dir_y < -ONE)
            y_clamp = -ONE;
        else
            y_clamp = dir_y;
        y_sq   = y_clamp * y_clamp;
        n_next = SQ_W'(ONE_SQ - y_sq);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= dir_x;
            z_reg[0]    <= dir_z;
            yc_reg[0]   <= y_clamp;
            n_reg[0]    <= n_next;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - i;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        assign rem_sh = {rem_reg[i][REM_W-3:0], n_reg[i][2*B+1 -: 2]};
        assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_reg[i], 2'b01};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[i+1]  <= rem_sh - trial;
                    root_reg[i+1] <= {root_reg[i][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1]  <= rem_sh;
                    root_reg[i+1] <= {root_reg[i][ROOT_W-2:0], 1'b0};
                end
                x_reg[i+1]  <= x_reg[i];
                z_reg[i+1]  <= z_reg[i];
                yc_reg[i+1] <= yc_reg[i];
                n_reg[i+1]  <= n_reg[i];
            end
        end
    end

    sdp_angle #(
        .STAGES (CORDIC_STAGES)
    ) u_azimuth (
        .clk    (clk),
        .en     (adv),
        .re_in  (z_reg[ROOT_W]),
        .im_in  (x_reg[ROOT_W]),
        .angle  (az_ang)
    );

    sdp_angle #(
        .STAGES (CORDIC_STAGES)
    ) u_polar (
        .clk    (clk),
        .en     (adv),
        .re_in  (yc_reg[ROOT_W]),
        .im_in  (signed'({{(IW-ROOT_W){1'b0}}, root_reg[ROOT_W]})),
        .angle  (pol_ang)
    );

    always_comb
    begin
        a_val = GW'(az_ang) + 33'd2147483648;
        if (pol_ang[GW-1])
            b_val = 32'd2147483648;
        else
            b_val = 32'd2147483648 - pol_ang[31:0];
        prod_u = 47'(a_val) * 47'(width_reg);
        prod_v = 45'(b_val) * 45'(height_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg <= prod_u[32-PFB +: sdp_pkg::U_W];
            v_reg <= prod_v[31-PFB +: sdp_pkg::V_W];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sdp_angle.sv =====
// ----------------------------------------------------------------------------
// sdp_angle
// Pipelined vectoring CORDIC that returns the angle of a vector as a binary
// angle (pi = 2^31), clamped to plus or minus pi.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdp_angle #(
    parameter int STAGES = sdp_pkg::CORDIC_STAGES
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [sdp_pkg::IN_W-1:0]   re_in,
    input  wire logic signed [sdp_pkg::IN_W-1:0]   im_in,
    output logic signed [sdp_pkg::ANG_W-1:0]       angle
);

    localparam int DW = sdp_pkg::DATA_W;
    localparam int AW = sdp_pkg::ACC_W;
    localparam int GW = sdp_pkg::ANG_W;
    localparam logic signed [AW-1:0] PI_ACC = AW'(64'sd2147483648);
    localparam logic signed [GW-1:0] PI_ANG = GW'(64'sd2147483648);
    localparam logic signed [GW-1:0] HALF_PI_ANG = GW'(64'sd1073741824);

    logic signed [DW-1:0] re_reg [0:STAGES];
    logic signed [DW-1:0] im_reg [0:STAGES];
    logic signed [AW-1:0] acc_reg [0:STAGES];
    logic                 spec_reg [0:STAGES];
    logic signed [GW-1:0] spec_ang_reg [0:STAGES];
    logic signed [GW-1:0] angle_reg;

    logic signed [DW-1:0] re_ext;
    logic signed [DW-1:0] im_ext;
    logic signed [DW-1:0] re_next;
    logic signed [DW-1:0] im_next;
    logic signed [AW-1:0] acc_next;
    logic                 spec_next;
    logic signed [GW-1:0] spec_ang_next;
    logic signed [GW-1:0] angle_next;

    always_comb
    begin
        re_ext = {{(DW-sdp_pkg::IN_W-sdp_pkg::GUARD_W){re_in[sdp_pkg::IN_W-1]}},
                  re_in, {sdp_pkg::GUARD_W{1'b0}}};
        im_ext = {{(DW-sdp_pkg::IN_W-sdp_pkg::GUARD_W){im_in[sdp_pkg::IN_W-1]}},
                  im_in, {sdp_pkg::GUARD_W{1'b0}}};
        spec_next = 1'b0;
        spec_ang_next = '0;
        re_next = re_ext;
        im_next = im_ext;
        acc_next = '0;
        if (im_in == '0)
        begin
            spec_next = 1'b1;
            spec_ang_next = re_in[sdp_pkg::IN_W-1] ? PI_ANG : '0;
        end
        else if (re_in == '0)
        begin
            spec_next = 1'b1;
            spec_ang_next = im_in[sdp_pkg::IN_W-1] ? -HALF_PI_ANG : HALF_PI_ANG;
        end
        if (re_in[sdp_pkg::IN_W-1])
        begin
            acc_next = im_in[sdp_pkg::IN_W-1] ? -PI_ACC : PI_ACC;
            re_next = -re_ext;
            im_next = -im_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg[0] <= re_next;
            im_reg[0] <= im_next;
            acc_reg[0] <= acc_next;
            spec_reg[0] <= spec_next;
            spec_ang_reg[0] <= spec_ang_next;
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_iter
        logic signed [AW-1:0] step;
        assign step = AW'(signed'({1'b0, sdp_pkg::atan_at(k)}));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!im_reg[k][DW-1])
                begin
                    re_reg[k+1] <= re_reg[k] + (im_reg[k] >>> k);
                    im_reg[k+1] <= im_reg[k] - (re_reg[k] >>> k);
                    acc_reg[k+1] <= acc_reg[k] + step;
                end
                else
                begin
                    re_reg[k+1] <= re_reg[k] - (im_reg[k] >>> k);
                    im_reg[k+1] <= im_reg[k] + (re_reg[k] >>> k);
                    acc_reg[k+1] <= acc_reg[k] - step;
                end
                spec_reg[k+1] <= spec_reg[k];
                spec_ang_reg[k+1] <= spec_ang_reg[k];
            end
        end
    end

    always_comb
    begin
        if (spec_reg[STAGES])
            angle_next = spec_ang_reg[STAGES];
        else if (acc_reg[STAGES] > PI_ACC)
            angle_next = PI_ANG;
        else if (acc_reg[STAGES] < -PI_ACC)
            angle_next = -PI_ANG;
        else
            angle_next = acc_reg[STAGES][GW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

// ===== hdl/sdp_checker.sv =====
// ----------------------------------------------------------------------------
// sdp_checker
// Port-level checks on stalling and on held results, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_direction_to_pixel_defines.svh"

module sdp_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_ready,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [sdp_pkg::U_W-1:0]     pixel_u,
    input  wire logic [sdp_pkg::V_W-1:0]     pixel_v
);

    `SDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_u) && $stable(pixel_v), "Held item changed.")
    `SDP_ASSERT_SAME(a_stall_in, out_valid && !out_ready, !in_ready, "Input taken during stall.")
    `SDP_ASSERT_SAME(a_free_in, !out_valid, in_ready, "Input blocked with empty output.")

endmodule

bind sphere_direction_to_pixel sdp_checker u_sdp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_u   (pixel_u),
    .pixel_v   (pixel_v)
);

`default_nettype wire
